@@ design/cfd_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the frame deframer.
// No dependencies; every other design file but cfd_channels imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

   localparam int unsigned MAX_PAYLOAD_DEF = 255;
   localparam int unsigned QUEUE_DEPTH     = 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [2:0] {
      CSR_START_MARKER   = 3'd0,
      CSR_END_MARKER     = 3'd1,
      CSR_COUNT_OFFSET   = 3'd2,
      CSR_KNOWN_SENDER_A = 3'd3,
      CSR_KNOWN_SENDER_B = 3'd4,
      CSR_KNOWN_SENDER_C = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK             = 3'd0,
      ST_BAD_START      = 3'd1,
      ST_BAD_LENGTH     = 3'd2,
      ST_BAD_END        = 3'd3,
      ST_BAD_CRC        = 3'd4,
      ST_UNKNOWN_SENDER = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_SRC   = 4'd1,
      PH_DST   = 4'd2,
      PH_IDLO  = 4'd3,
      PH_IDHI  = 4'd4,
      PH_LEN   = 4'd5,
      PH_CODE  = 4'd6,
      PH_DATA  = 4'd7,
      PH_CRCLO = 4'd8,
      PH_CRCHI = 4'd9,
      PH_END   = 4'd10
   } phase_type;

   typedef struct packed {
      logic [7:0] start_marker;
      logic [7:0] end_marker;
      logic [7:0] count_offset;
      logic [7:0] known_sender_a;
      logic [7:0] known_sender_b;
      logic [7:0] known_sender_c;
   } cfg_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [7:0] shifted;
      logic       is_start;
      logic       is_end;
      logic       len_bad;
   } item_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] sender_addr;
      logic [7:0] target_addr;
      logic [15:0] frame_number;
      logic [7:0] func_code;
      logic [7:0] payload_len;
      status_type status;
   } rsp_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] acc;
      acc = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ CRC_POLY;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

`default_nettype wire

@@ design/cfd_channels.sv @@
// Valid/ready channel interfaces for received bytes, results and register writes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [7:0]  payload_index;
   logic [7:0]  sender_addr;
   logic [7:0]  target_addr;
   logic [15:0] frame_number;
   logic [7:0]  func_code;
   logic [7:0]  payload_len;
   logic [2:0]  status;
   modport source (output valid, output kind, output payload_byte, output payload_index,
                   output sender_addr, output target_addr, output frame_number,
                   output func_code, output payload_len, output status, input ready);
   modport sink (input valid, input kind, input payload_byte, input payload_index,
                 input sender_addr, input target_addr, input frame_number,
                 input func_code, input payload_len, input status, output ready);
endinterface

interface cfd_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/cfd_front.sv @@
// Front stage: accepts received words, classifies each against the markers and
// the length limit, and holds it in a register for the queue. Uses cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfd_front #(
   parameter int unsigned MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cfd_pkg::cfg_type   cfg,
   cfd_req_if.sink            req_chan,
   output logic               push_valid,
   input  logic               push_ready,
   output cfd_pkg::item_type  push_item
);
   import cfd_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     take;

   always_comb begin
      item_in.rx_byte  = req_chan.rx_byte;
      item_in.shifted  = req_chan.rx_byte - cfg.count_offset;
      item_in.is_start = (req_chan.rx_byte == cfg.start_marker);
      item_in.is_end   = (req_chan.rx_byte == cfg.end_marker);
      item_in.len_bad  = (req_chan.rx_byte < cfg.count_offset) || (item_in.shifted > MAX_LEN);
   end

   assign req_chan.ready = !vld_ff || push_ready;
   assign take           = req_chan.valid && req_chan.ready;
   assign vld_in         = take || (vld_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign push_valid = vld_ff;
   assign push_item  = item_ff;

endmodule

`default_nettype wire

@@ design/cfd_queue.sv @@
// Short register queue between the front stage and the frame parser.
// Uses cfd_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module cfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  cfd_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output cfd_pkg::item_type  pop_item
);
   import cfd_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

   item_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ design/cfd_back.sv @@
// Frame parser: walks the frame fields, keeps the CRC-16, and drives the
// result register. Uses cfd_pkg and the cfd_rsp_if channel.
`timescale 1ns / 1ps
`default_nettype none

module cfd_back (
   input  logic               clock,
   input  logic               reset,
   input  cfd_pkg::cfg_type   cfg,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  cfd_pkg::item_type  pop_item,
   cfd_rsp_if.source          rsp_chan
);
   import cfd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  src_ff, src_in;
   logic [7:0]  dst_ff, dst_in;
   logic [15:0] id_ff, id_in;
   logic [7:0]  code_ff, code_in;
   logic [15:0] crcrx_ff, crcrx_in;
   logic        rsp_vld_ff, rsp_vld_in;
   rsp_type     rsp_ff, rsp_in;
   logic        emit;
   logic        take;
   logic        out_free;
   logic [15:0] crc_next;
   logic [7:0]  cnt_next;
   logic        sender_known;
   logic [7:0]  b;

   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign pop_ready = out_free;
   assign take      = pop_valid && out_free;
   assign b         = pop_item.rx_byte;
   assign crc_next  = crc16_byte(crc_ff, b);
   assign cnt_next  = cnt_ff + 8'd1;
   assign sender_known = (src_ff == cfg.known_sender_a) || (src_ff == cfg.known_sender_b) ||
                         (src_ff == cfg.known_sender_c);

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      crc_in   = crc_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      id_in    = id_ff;
      code_in  = code_ff;
      crcrx_in = crcrx_ff;
      emit     = 1'b0;
      rsp_in.kind          = KIND_SUMMARY;
      rsp_in.payload_byte  = '0;
      rsp_in.payload_index = '0;
      rsp_in.sender_addr   = src_ff;
      rsp_in.target_addr   = dst_ff;
      rsp_in.frame_number  = id_ff;
      rsp_in.func_code     = code_ff;
      rsp_in.payload_len   = len_ff;
      rsp_in.status        = ST_OK;
      if (take) begin
         unique case (phase_ff)
            PH_SRC: begin
               crc_in   = crc_next;
               src_in   = b;
               phase_in = PH_DST;
            end
            PH_DST: begin
               crc_in   = crc_next;
               dst_in   = b;
               phase_in = PH_IDLO;
            end
            PH_IDLO: begin
               crc_in   = crc_next;
               id_in    = {8'h00, pop_item.shifted};
               phase_in = PH_IDHI;
            end
            PH_IDHI: begin
               crc_in   = crc_next;
               id_in    = {pop_item.shifted, id_ff[7:0]};
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (pop_item.len_bad) begin
                  emit                = 1'b1;
                  rsp_in.payload_len  = pop_item.shifted;
                  rsp_in.status       = ST_BAD_LENGTH;
                  phase_in = PH_HUNT;
                  cnt_in   = '0;
                  len_in   = '0;
                  crc_in   = CRC_INIT;
                  src_in   = '0;
                  dst_in   = '0;
                  id_in    = '0;
                  code_in  = '0;
                  crcrx_in = '0;
               end else begin
                  crc_in   = crc_next;
                  len_in   = pop_item.shifted;
                  phase_in = PH_CODE;
               end
            end
            PH_CODE: begin
               crc_in   = crc_next;
               code_in  = b;
               cnt_in   = '0;
               phase_in = (len_ff == 8'd0) ? PH_CRCLO : PH_DATA;
            end
            PH_DATA: begin
               crc_in               = crc_next;
               emit                 = 1'b1;
               rsp_in.kind          = KIND_PAYLOAD;
               rsp_in.payload_byte  = b;
               rsp_in.payload_index = cnt_ff;
               cnt_in               = cnt_next;
               if (cnt_next >= len_ff) begin
                  phase_in = PH_CRCLO;
               end
            end
            PH_CRCLO: begin
               crcrx_in = {8'h00, b};
               phase_in = PH_CRCHI;
            end
            PH_CRCHI: begin
               crcrx_in = {b, crcrx_ff[7:0]};
               phase_in = PH_END;
            end
            PH_END: begin
               emit = 1'b1;
               priority if (!pop_item.is_end) begin
                  rsp_in.status = ST_BAD_END;
               end else if (crcrx_ff != crc_ff) begin
                  rsp_in.status = ST_BAD_CRC;
               end else if (!sender_known) begin
                  rsp_in.status = ST_UNKNOWN_SENDER;
               end else begin
                  rsp_in.status = ST_OK;
               end
               phase_in = PH_HUNT;
               cnt_in   = '0;
               len_in   = '0;
               crc_in   = CRC_INIT;
               src_in   = '0;
               dst_in   = '0;
               id_in    = '0;
               code_in  = '0;
               crcrx_in = '0;
            end
            default: begin
               cnt_in   = '0;
               len_in   = '0;
               src_in   = '0;
               dst_in   = '0;
               id_in    = '0;
               code_in  = '0;
               crcrx_in = '0;
               if (pop_item.is_start) begin
                  crc_in   = crc16_byte(CRC_INIT, b);
                  phase_in = PH_SRC;
               end else begin
                  crc_in               = CRC_INIT;
                  phase_in             = PH_HUNT;
                  emit                 = 1'b1;
                  rsp_in.status        = ST_BAD_START;
                  rsp_in.sender_addr   = '0;
                  rsp_in.target_addr   = '0;
                  rsp_in.frame_number  = '0;
                  rsp_in.func_code     = '0;
                  rsp_in.payload_len   = '0;
               end
            end
         endcase
      end
   end

   assign rsp_vld_in = (take && emit) || (rsp_vld_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HUNT;
         cnt_ff     <= '0;
         len_ff     <= '0;
         crc_ff     <= CRC_INIT;
         src_ff     <= '0;
         dst_ff     <= '0;
         id_ff      <= '0;
         code_ff    <= '0;
         crcrx_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         len_ff     <= len_in;
         crc_ff     <= crc_in;
         src_ff     <= src_in;
         dst_ff     <= dst_in;
         id_ff      <= id_in;
         code_ff    <= code_in;
         crcrx_ff   <= crcrx_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.kind          = rsp_ff.kind;
   assign rsp_chan.payload_byte  = rsp_ff.payload_byte;
   assign rsp_chan.payload_index = rsp_ff.payload_index;
   assign rsp_chan.sender_addr   = rsp_ff.sender_addr;
   assign rsp_chan.target_addr   = rsp_ff.target_addr;
   assign rsp_chan.frame_number  = rsp_ff.frame_number;
   assign rsp_chan.func_code     = rsp_ff.func_code;
   assign rsp_chan.payload_len   = rsp_ff.payload_len;
   assign rsp_chan.status        = 3'(rsp_ff.status);

endmodule

`default_nettype wire

@@ design/crc16_frame_deframer.sv @@
// Frame deframer with CRC-16/MODBUS check: top level with the register bank.
// Depends on cfd_pkg, cfd_channels, cfd_front, cfd_queue and cfd_back.
// Path: a received word passes the front register, the queue and the result register.
// Throughput: one word per cycle while the result channel is not stalled; the byte-wide CRC update is combinational.
// Reset: synchronous; registers read 0, the queue empties, the parser hunts.
`timescale 1ns / 1ps
`default_nettype none

module crc16_frame_deframer #(
   parameter int unsigned MAX_PAYLOAD = cfd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cfd_req_if.sink   req_chan,
   cfd_rsp_if.source rsp_chan,
   cfd_csr_if.sink   csr_chan
);
   import cfd_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, push_ready, pop_valid, pop_ready;
   item_type push_item, pop_item;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_START_MARKER:   cfg_in.start_marker   = csr_chan.data;
            CSR_END_MARKER:     cfg_in.end_marker     = csr_chan.data;
            CSR_COUNT_OFFSET:   cfg_in.count_offset   = csr_chan.data;
            CSR_KNOWN_SENDER_A: cfg_in.known_sender_a = csr_chan.data;
            CSR_KNOWN_SENDER_B: cfg_in.known_sender_b = csr_chan.data;
            CSR_KNOWN_SENDER_C: cfg_in.known_sender_c = csr_chan.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfd_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item (push_item)
   );

   cfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_item (push_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item)
   );

   cfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_item (pop_item),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
